[rtl/pba_pkg.sv]
// Shared constants, codes and types of the page bitmap allocator.
package pba_pkg;

  localparam int unsigned PAGE_COUNT_DEF = 4096;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned BYTES_W    = 32;
  localparam int unsigned KIND_W     = 8;
  localparam int unsigned USE_CNT_W  = 13;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_ROOM  = 2'd1,
    STAT_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_SCAN,
    ST_MARK,
    ST_FCHK,
    ST_FREAD,
    ST_FLEN,
    ST_FCLR,
    ST_DONE
  } state_t;

endpackage

[rtl/pba_in_if.sv]
// Request channel of the page bitmap allocator: valid/ready plus request fields.
interface pba_in_if;
  import pba_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [BYTES_W-1:0] alloc_bytes;
  logic [KIND_W-1:0]  alloc_kind;
  logic [ADDR_W-1:0]  free_address;

  modport source (
    output valid, operation, alloc_bytes, alloc_kind, free_address,
    input  ready
  );

  modport sink (
    input  valid, operation, alloc_bytes, alloc_kind, free_address,
    output ready
  );

endinterface

[rtl/pba_out_if.sv]
// Result channel of the page bitmap allocator: valid/ready plus result fields.
interface pba_out_if;
  import pba_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ADDR_W-1:0]    result_address;
  logic [STATUS_W-1:0]  status;
  logic [USE_CNT_W-1:0] pages_in_use;

  modport source (
    output valid, result_address, status, pages_in_use,
    input  ready
  );

  modport sink (
    input  valid, result_address, status, pages_in_use,
    output ready
  );

endinterface

[rtl/pba_map.sv]
// Per-page map memory: one write port, one read port with registered data.
module pba_map #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/page_bitmap_allocator_core.sv]
// Top level of the first-fit page bitmap allocator: sequencer, counters and map memory.
//
// Usage: requests arrive on in_ch (valid/ready); a transfer with operation = allocate
// asks for alloc_bytes rounded up to whole pages, one with operation = free hands back
// the run that starts at free_address. Each request produces exactly one transfer on
// out_ch carrying result_address, status and the used-page count after the request.
// cfg_we/cfg_wdata load region_base; write it only while no request is in flight.
// Allocate scans the map one page per cycle through the single map read port,
// starting at the first page of the last allocated or freed run, and then marks
// the run one page per cycle through the write port. A zero-size or oversized
// allocate fails without a scan. Free reads and clears the run's first page, then
// clears the rest of the run; an out-of-range free leaves the map untouched.
// One request is worked on at a time; in_ch.ready is high only while the sequencer idles.
// Reset (rst_n low, synchronous) clears the counters and starts a clearing pass over
// every page of the map memory; no request is taken until it ends.
// A result sits in the output register until out_ch.ready takes it; the next request
// can be accepted and processed meanwhile, and only its final load waits for the slot.
module page_bitmap_allocator_core #(
  parameter int unsigned PAGE_COUNT = pba_pkg::PAGE_COUNT_DEF,
  parameter int unsigned PAGE_SHIFT = pba_pkg::PAGE_SHIFT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pba_pkg::ADDR_W-1:0]  cfg_wdata,
  pba_in_if.sink                      in_ch,
  pba_out_if.source                   out_ch
);
  import pba_pkg::*;

  // Index, count and map word geometry.
  localparam int unsigned PIDX_W = $clog2(PAGE_COUNT);
  localparam int unsigned CNT_W  = $clog2(PAGE_COUNT + 1);
  localparam int unsigned WANT_W = BYTES_W + 1;
  localparam int unsigned WORD_W = 1 + CNT_W + KIND_W;

  localparam logic [PIDX_W:0]   PAGE_LIMIT = (PIDX_W + 1)'(PAGE_COUNT);
  localparam logic [PIDX_W-1:0] LAST_PAGE  = PIDX_W'(PAGE_COUNT - 1);
  localparam logic [WANT_W-1:0] PAGE_MASK  = WANT_W'((64'd1 << PAGE_SHIFT) - 64'd1);

  // Sequencer and datapath registers.
  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    base_r, base_nxt;
  logic [WANT_W-1:0]    want_r, want_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [ADDR_W-1:0]    faddr_r, faddr_nxt;
  logic [CNT_W-1:0]     pages_used_r, pages_used_nxt;
  logic [PIDX_W-1:0]    search_start_r, search_start_nxt;
  logic [PIDX_W:0]      issue_r, issue_nxt;
  logic                 pend_r, pend_nxt;
  logic [PIDX_W-1:0]    pend_page_r, pend_page_nxt;
  logic [CNT_W-1:0]     run_r, run_nxt;
  logic [PIDX_W-1:0]    first_r, first_nxt;
  logic [PIDX_W-1:0]    cur_r, cur_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  status_t              status_r, status_nxt;
  logic                 alloc_ok_r, alloc_ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [USE_CNT_W-1:0] out_used_r, out_used_nxt;

  // Map memory port.
  logic                 mem_we;
  logic [PIDX_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [PIDX_W-1:0]    mem_raddr;
  logic [WORD_W-1:0]    mem_rdata;

  // Decoded map word and shared conditions.
  logic                 rd_used;
  logic [CNT_W-1:0]     rd_len;
  logic                 want_bad;
  logic                 issue_ok;
  logic [CNT_W-1:0]     run_inc;
  logic                 hit;
  logic                 exhausted;
  logic [ADDR_W-1:0]    free_diff;
  logic [ADDR_W-1:0]    free_page;
  logic                 free_ok;
  logic                 out_slot_free;

  pba_map #(
    .DEPTH (PAGE_COUNT),
    .WIDTH (WORD_W)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Word layout: {in_use, run_length, run_kind}.
  assign rd_used = mem_rdata[WORD_W-1];
  assign rd_len  = mem_rdata[KIND_W +: CNT_W];

  // Zero-page and larger-than-map requests fail without a scan.
  assign want_bad  = (want_r == '0) || (want_r > WANT_W'(PAGE_COUNT));
  assign issue_ok  = (issue_r < PAGE_LIMIT);
  assign run_inc   = run_r + 1'b1;
  // The page whose data arrives this cycle completes the run.
  assign hit       = pend_r && !rd_used && (WANT_W'(run_inc) == want_r);
  // Nothing left to issue and nothing in flight: no room without wrapping.
  assign exhausted = !pend_r && !issue_ok;

  // Free address to page index; offset inside the page is dropped.
  assign free_diff = faddr_r - base_r;
  assign free_page = free_diff >> PAGE_SHIFT;
  assign free_ok   = (faddr_r >= base_r) && (free_page < ADDR_W'(PAGE_COUNT));

  assign out_slot_free = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cur_r == LAST_PAGE) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (op_t'(in_ch.operation) == OP_FREE) ? ST_FCHK : ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        state_nxt = want_bad ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_MARK;
        end else if (exhausted) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MARK: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_FCHK: begin
        state_nxt = free_ok ? ST_FREAD : ST_DONE;
      end
      ST_FREAD: begin
        state_nxt = ST_FLEN;
      end
      ST_FLEN: begin
        state_nxt = (rd_len > CNT_W'(1)) ? ST_FCLR : ST_DONE;
      end
      ST_FCLR: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Handshake and map memory controls.
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    mem_we      = 1'b0;
    mem_waddr   = cur_r;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = issue_r[PIDX_W-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_SCAN: begin
        mem_re = issue_ok;
      end
      ST_MARK: begin
        // First page carries the run's length and kind; the rest only the use bit.
        mem_we = 1'b1;
        if (cur_r == first_r) begin
          mem_wdata = {1'b1, CNT_W'(want_r), kind_r};
        end else begin
          mem_wdata = {1'b1, {(CNT_W + KIND_W){1'b0}}};
        end
      end
      ST_FREAD: begin
        mem_re    = 1'b1;
        mem_raddr = first_r;
      end
      ST_FLEN: begin
        // A page that starts no run keeps its use bit; length and kind clear.
        mem_we    = 1'b1;
        mem_waddr = first_r;
        mem_wdata = {(rd_len == '0) ? rd_used : 1'b0, {(CNT_W + KIND_W){1'b0}}};
      end
      ST_FCLR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    base_nxt         = base_r;
    want_nxt         = want_r;
    kind_nxt         = kind_r;
    faddr_nxt        = faddr_r;
    pages_used_nxt   = pages_used_r;
    search_start_nxt = search_start_r;
    issue_nxt        = issue_r;
    pend_nxt         = pend_r;
    pend_page_nxt    = pend_page_r;
    run_nxt          = run_r;
    first_nxt        = first_r;
    cur_nxt          = cur_r;
    cnt_nxt          = cnt_r;
    status_nxt       = status_r;
    alloc_ok_nxt     = alloc_ok_r;
    out_valid_nxt    = out_valid_r;
    out_addr_nxt     = out_addr_r;
    out_status_nxt   = out_status_r;
    out_used_nxt     = out_used_r;

    if (cfg_we) begin
      base_nxt = cfg_wdata;
    end

    // Drop the held result once the receiver takes it.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        cur_nxt = cur_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          want_nxt  = (WANT_W'(in_ch.alloc_bytes) + PAGE_MASK) >> PAGE_SHIFT;
          kind_nxt  = in_ch.alloc_kind;
          faddr_nxt = in_ch.free_address;
        end
      end
      ST_ALLOC: begin
        issue_nxt    = {1'b0, search_start_r};
        pend_nxt     = 1'b0;
        run_nxt      = '0;
        status_nxt   = STAT_NO_ROOM;
        alloc_ok_nxt = 1'b0;
      end
      ST_SCAN: begin
        // Issue the next page while checking the one whose data just arrived.
        pend_nxt      = issue_ok;
        pend_page_nxt = issue_r[PIDX_W-1:0];
        if (issue_ok) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (pend_r) begin
          run_nxt = rd_used ? '0 : run_inc;
        end
        if (hit) begin
          first_nxt = pend_page_r - PIDX_W'(run_r);
          cur_nxt   = pend_page_r - PIDX_W'(run_r);
          cnt_nxt   = CNT_W'(want_r);
        end
      end
      ST_MARK: begin
        cur_nxt = cur_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          pages_used_nxt   = pages_used_r + CNT_W'(want_r);
          search_start_nxt = first_r;
          status_nxt       = STAT_OK;
          alloc_ok_nxt     = 1'b1;
        end
      end
      ST_FCHK: begin
        first_nxt    = free_page[PIDX_W-1:0];
        status_nxt   = free_ok ? STAT_OK : STAT_BAD_FREE;
        alloc_ok_nxt = 1'b0;
      end
      ST_FLEN: begin
        // Saturate the used count at zero.
        pages_used_nxt   = (rd_len > pages_used_r) ? '0 : pages_used_r - rd_len;
        search_start_nxt = first_r;
        cur_nxt          = first_r + 1'b1;
        cnt_nxt          = rd_len - 1'b1;
      end
      ST_FCLR: begin
        cur_nxt = cur_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
      end
      ST_DONE: begin
        if (out_slot_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = alloc_ok_r ? base_r + (ADDR_W'(first_r) << PAGE_SHIFT) : '0;
          out_status_nxt = status_r;
          out_used_nxt   = USE_CNT_W'(pages_used_r);
        end
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      base_r         <= '0;
      pages_used_r   <= '0;
      search_start_r <= '0;
      cur_r          <= '0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      base_r         <= base_nxt;
      pages_used_r   <= pages_used_nxt;
      search_start_r <= search_start_nxt;
      cur_r          <= cur_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    want_r       <= want_nxt;
    kind_r       <= kind_nxt;
    faddr_r      <= faddr_nxt;
    issue_r      <= issue_nxt;
    pend_page_r  <= pend_page_nxt;
    run_r        <= run_nxt;
    first_r      <= first_nxt;
    cnt_r        <= cnt_nxt;
    status_r     <= status_nxt;
    alloc_ok_r   <= alloc_ok_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.pages_in_use   = out_used_r;

endmodule

[bench/page_bitmap_allocator_core_tb.sv]
// Self-checking testbench for the first-fit page bitmap allocator core.
`timescale 1ns / 100ps

module page_bitmap_allocator_core_tb;
  import pba_pkg::*;

  localparam int unsigned PAGES      = PAGE_COUNT_DEF;
  localparam int unsigned PAGE_BITS  = PAGE_SHIFT_DEF;
  localparam int unsigned PAGE_BYTES = 1 << PAGE_BITS;
  localparam int unsigned PAUSE_MAX  = 40;

  // One result transfer as the allocator should produce it.
  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    status_t              status;
    logic [USE_CNT_W-1:0] used;
  } alloc_result_t;

  // Page map shadow plus the queue of results still owed by the block.
  class alloc_scoreboard;
    logic [ADDR_W-1:0] base_addr;
    bit                page_taken [PAGES];
    int unsigned       run_pages [PAGES];
    logic [KIND_W-1:0] run_tag [PAGES];
    int unsigned       taken_count;
    int unsigned       scan_start;
    alloc_result_t     pending_results [$];
    int unsigned       fail_count;
    int unsigned       work_cycles;
    int                last_first;

    function new();
      base_addr   = '0;
      taken_count = 0;
      scan_start  = 0;
      fail_count  = 0;
      work_cycles = 0;
      last_first  = -1;
      foreach (run_tag[i]) run_tag[i] = '0;
    endfunction

    // Apply one accepted request to the shadow map and queue its result.
    function void note_request(op_t op, logic [BYTES_W-1:0] bytes, logic [KIND_W-1:0] kind,
                               logic [ADDR_W-1:0] addr);
      longint unsigned   want;
      logic [ADDR_W-1:0] page;
      int unsigned       p, q, run, first;
      alloc_result_t     res;
      res.addr    = '0;
      res.status  = STAT_OK;
      last_first  = -1;
      work_cycles = 3;
      if (op == OP_ALLOC) begin
        want = bytes;
        want = (want + PAGE_BYTES - 1) >> PAGE_BITS;
        res.status = STAT_NO_ROOM;
        if (want != 0 && want <= PAGES) begin
          p   = scan_start;
          run = 0;
          while (p < PAGES && run != want) begin
            if (page_taken[p]) run = 0;
            else run++;
            p++;
          end
          work_cycles = 4 + (p - scan_start);
          if (run == want) begin
            first = p - run;
            for (q = first; q < p; q++) page_taken[q] = 1'b1;
            run_pages[first] = run;
            run_tag[first]   = kind;
            taken_count     += run;
            scan_start       = first;
            res.addr         = base_addr + (ADDR_W'(first) << PAGE_BITS);
            res.status       = STAT_OK;
            last_first       = first;
            work_cycles     += run;
          end
        end
      end else if (addr >= base_addr) begin
        page = (addr - base_addr) >> PAGE_BITS;
        if (page < PAGES) begin
          first = 32'(page);
          run   = run_pages[first];
          for (q = first; q < first + run && q < PAGES; q++) page_taken[q] = 1'b0;
          run_pages[first] = 0;
          run_tag[first]   = '0;
          taken_count      = (run > taken_count) ? 0 : taken_count - run;
          scan_start       = first;
          work_cycles      = 5 + run;
        end else begin
          res.status = STAT_BAD_FREE;
        end
      end else begin
        res.status = STAT_BAD_FREE;
      end
      res.used = USE_CNT_W'(taken_count);
      pending_results.push_back(res);
    endfunction

    // Compare one result transfer with the oldest queued result.
    function void check_result(logic [ADDR_W-1:0] addr, logic [STATUS_W-1:0] status,
                               logic [USE_CNT_W-1:0] used);
      alloc_result_t exp_res;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with none expected: address %h status %0d pages %0d",
                 $time, addr, status, used);
        return;
      end
      exp_res = pending_results.pop_front();
      if (addr !== exp_res.addr) begin
        fail_count++;
        $display("%0t: result_address expected %h actual %h", $time, exp_res.addr, addr);
      end
      if (status !== exp_res.status) begin
        fail_count++;
        $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
      end
      if (used !== exp_res.used) begin
        fail_count++;
        $display("%0t: pages_in_use expected %0d actual %0d", $time, exp_res.used, used);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  pba_in_if  in_ch ();
  pba_out_if out_ch ();

  page_bitmap_allocator_core #(
    .PAGE_COUNT(PAGES),
    .PAGE_SHIFT(PAGE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  alloc_scoreboard sb;
  int unsigned     live_runs [$];  // first pages of runs believed to be allocated
  bit              steady;         // when set, neither side inserts idle cycles
  longint          budget;         // cycles the accepted work may reasonably take
  longint          cycle_count;

  always #1 clk = ~clk;

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pause_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, PAUSE_MAX);
  endfunction

  // Byte address of a page under the current region base (wraps modulo 2^64).
  function automatic logic [ADDR_W-1:0] page_addr(int unsigned idx);
    return sb.base_addr + (ADDR_W'(idx) << PAGE_BITS);
  endfunction

  // Result side: alternate ready stretches with stalls of random length.
  initial begin
    int unsigned n;
    forever begin
      n = steady ? 0 : pause_len();
      if (n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Check every result transfer against the shadow map's prediction.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.result_address, out_ch.status, out_ch.pages_in_use);
  end

  // Watchdog: the limit grows with the work accepted, so a hang ends the run.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > 4 * budget + 10 * PAGES + 10000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive one request and hold it until the block takes it; then predict its result.
  task automatic put_request(op_t op, logic [BYTES_W-1:0] bytes, logic [KIND_W-1:0] kind,
                             logic [ADDR_W-1:0] addr);
    int unsigned n;
    n = steady ? 0 : pause_len();
    if (n != 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.alloc_bytes  <= bytes;
    in_ch.alloc_kind   <= kind;
    in_ch.free_address <= addr;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(op, bytes, kind, addr);
    budget += sb.work_cycles + 2 * PAUSE_MAX + 8;
    if (sb.last_first >= 0) live_runs.push_back(sb.last_first);
  endtask

  // Drop valid and hold off until every owed result has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Load region_base; call only with the block idle.
  task automatic load_base(logic [ADDR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.base_addr  = value;
  endtask

  // One random request: mostly small allocations and frees of live runs, with
  // oversized, zero, stray and out-of-range requests mixed in. Unused fields stay random.
  task automatic random_request();
    int unsigned       roll, pages, pick, idx;
    bit                heavy;
    logic [ADDR_W-1:0] noise;
    roll  = $urandom_range(0, 199);
    heavy = sb.taken_count > PAGES / 2;
    noise = {$urandom, $urandom};
    if (roll < (heavy ? 50 : 100)) begin
      pages = $urandom_range(1, 8);
      put_request(OP_ALLOC, (pages - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES),
                  KIND_W'($urandom), noise);
    end else if (roll < (heavy ? 60 : 116)) begin
      pages = $urandom_range(9, 128);
      put_request(OP_ALLOC, (pages - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES),
                  KIND_W'($urandom), noise);
    end else if (roll < 122) begin
      put_request(OP_ALLOC, $urandom, KIND_W'($urandom), noise);
    end else if (roll < 123) begin
      put_request(OP_ALLOC, ($urandom_range(0, 1) == 1) ? PAGES * PAGE_BYTES : 0,
                  KIND_W'($urandom), noise);
    end else if (roll < 184) begin
      if (live_runs.size() != 0) begin
        pick = $urandom_range(0, live_runs.size() - 1);
        idx  = live_runs[pick];
        live_runs.delete(pick);
      end else begin
        idx = $urandom_range(0, PAGES - 1);
      end
      put_request(OP_FREE, $urandom, KIND_W'($urandom),
                  page_addr(idx) + $urandom_range(0, PAGE_BYTES - 1));
    end else if (roll < 192) begin
      put_request(OP_FREE, $urandom, KIND_W'($urandom),
                  page_addr($urandom_range(0, PAGES - 1)));
    end else if (roll < 196) begin
      put_request(OP_FREE, $urandom, KIND_W'($urandom), noise);
    end else begin
      // just below the region, or anywhere when the region starts at zero
      put_request(OP_FREE, $urandom, KIND_W'($urandom),
                  (sb.base_addr != 0) ? sb.base_addr - 1 - $urandom_range(0, 4 * PAGE_BYTES)
                                      : noise);
    end
  endtask

  // Random requests in chunks; each chunk picks its idling and may first drain.
  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        if (i != 0 && $urandom_range(0, 3) == 0) drain();
      end
      random_request();
    end
  endtask

  initial begin
    sb = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_ALLOC;
    in_ch.alloc_bytes  <= '0;
    in_ch.alloc_kind   <= '0;
    in_ch.free_address <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    load_base('0);

    // Directed: size rounding, oversized and zero requests, tail overflow, frees
    // inside a page, of a page with no run, past the map, and the whole map at once.
    put_request(OP_ALLOC, '0, 8'h00, '1);
    put_request(OP_ALLOC, 32'd1, 8'hFF, '0);
    put_request(OP_ALLOC, PAGE_BYTES, 8'h00, '0);
    put_request(OP_ALLOC, PAGE_BYTES + 1, 8'hA5, '0);
    put_request(OP_ALLOC, '1, 8'h5A, '0);
    put_request(OP_ALLOC, PAGES * PAGE_BYTES, 8'h3C, '0);
    put_request(OP_FREE, '1, '1, page_addr(1) + PAGE_BYTES - 1);
    put_request(OP_FREE, '0, '0, page_addr(3));
    put_request(OP_FREE, $urandom, KIND_W'($urandom), page_addr(PAGES));
    put_request(OP_FREE, $urandom, KIND_W'($urandom), '1);
    put_request(OP_FREE, $urandom, KIND_W'($urandom), page_addr(PAGES - 1));
    put_request(OP_ALLOC, 2 * PAGE_BYTES, 8'h11, '0);
    put_request(OP_ALLOC, PAGE_BYTES, 8'h22, '0);
    put_request(OP_FREE, $urandom, KIND_W'($urandom), page_addr(PAGES - 1));
    put_request(OP_FREE, $urandom, KIND_W'($urandom), page_addr(2));
    put_request(OP_FREE, $urandom, KIND_W'($urandom), page_addr(0));
    put_request(OP_ALLOC, PAGES * PAGE_BYTES, 8'h77, '0);
    put_request(OP_ALLOC, 32'd1, 8'h88, '0);
    put_request(OP_FREE, $urandom, KIND_W'($urandom), page_addr(0));
    put_request(OP_ALLOC, 5 * PAGE_BYTES - 1, KIND_W'($urandom), '0);
    drain();

    // Random phases over several region bases; drain before every base change.
    run_random(450);
    drain();
    load_base('1);
    run_random(150);
    drain();
    load_base(64'hFFFF_FFFF_FFF8_0000);
    run_random(350);
    drain();
    load_base({$urandom, $urandom} & ~ADDR_W'(PAGE_BYTES - 1));
    run_random(350);
    drain();
    load_base({$urandom, $urandom});
    run_random(300);

    drain();
    repeat (20) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial cycle_count = 0;

endmodule

[page_bitmap_allocator_core.f]
rtl/pba_pkg.sv
rtl/pba_in_if.sv
rtl/pba_out_if.sv
rtl/pba_map.sv
rtl/page_bitmap_allocator_core.sv
bench/page_bitmap_allocator_core_tb.sv
